// ===== src/lasc_pkg.sv =====
// ----------------------------------------------------------------------------
// lasc_pkg: shared types and constants for the local alignment scorer
// Score width, scoring constants, register indexes and the wavefront record
// that travels from cell to cell.
// ----------------------------------------------------------------------------
package lasc_pkg;

    localparam int SCORE_W = 5;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCORE_W-1:0] SCORE_MATCH    = 5'd1;
    localparam logic [SCORE_W-1:0] SCORE_MISMATCH = 5'd8;
    localparam logic [SCORE_W-1:0] SCORE_GAP      = 5'd4;

    typedef logic [SCORE_W-1:0] t_score;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_idx;

    // One keyword byte as it moves down the row of cells
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_v;
        logic              last;
        t_score            left;
        t_score            diag;
        t_score            best;
    } t_wave;

    function automatic t_score score_max(input t_score a, input t_score b);
        return (a > b) ? a : b;
    endfunction

    // Subtract a penalty, floored at zero
    function automatic t_score score_sub(input t_score a, input t_score p);
        return (a >= p) ? t_score'(a - p) : '0;
    endfunction

endpackage

// ===== src/lasc_cell.sv =====
// ----------------------------------------------------------------------------
// lasc_cell: one pattern position of the systolic scoring row
// Holds the row score of its position, scores the passing keyword byte
// against its pattern byte and hands the wavefront to the next cell.
// ----------------------------------------------------------------------------
module lasc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_active,
    input  logic [7:0]            i_pattern_char,
    input  lasc_pkg::t_wave       i_wave,
    output lasc_pkg::t_wave       o_wave
);
    import lasc_pkg::*;

    t_score r_row, n_row;
    t_wave  r_wave, n_wave;
    t_score diag_term;
    t_score cell_score;

    // Score this byte from the diagonal, upper and left neighbors
    always_comb begin
        if (i_wave.char_v == i_pattern_char) begin
            diag_term = t_score'(i_wave.diag + SCORE_MATCH);
        end else begin
            diag_term = score_sub(i_wave.diag, SCORE_MISMATCH);
        end
        cell_score = score_max(diag_term,
                               score_max(score_sub(r_row, SCORE_GAP),
                                         score_sub(i_wave.left, SCORE_GAP)));
    end

    // Build the record for the next cell and the new row value
    always_comb begin
        n_row  = r_row;
        n_wave = i_wave;
        if (i_wave.valid) begin
            if (i_active) begin
                n_row       = i_wave.last ? '0 : cell_score;
                n_wave.left = cell_score;
                n_wave.diag = r_row;
                n_wave.best = score_max(i_wave.best, cell_score);
            end else begin
                n_row       = '0;
                n_wave.left = '0;
                n_wave.diag = '0;
            end
        end
    end

    // Advance the row as a whole; hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_wave.valid <= 1'b0;
        end else if (i_advance) begin
            r_row  <= n_row;
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule

// ===== src/local_alignment_score.sv =====
// ----------------------------------------------------------------------------
// local_alignment_score: Smith-Waterman local alignment score
// Scores a configured pattern of up to PATTERN_MAX bytes against a keyword
// streamed one byte per transaction, linear gap, cells floored at zero.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------
//  keyword   | in        | i_valid / o_ready    | i_keyword_char, i_keyword_last
//  score     | out       | o_valid / i_ready    | o_best_score, o_is_match
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// While the row advances, one keyword byte enters per cycle and each byte
// moves through one cell per cycle; a score is registered as a last byte leaves.
// The row of cells advances as a whole; it stalls only when a last byte
// reaches the end of the row while a score is still waiting to be taken.
// Synchronous active-low reset clears the row, the running best and config.
// ----------------------------------------------------------------------------
module local_alignment_score #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_keyword_char,
    input  logic                            i_keyword_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [4:0]                      o_best_score,
    output logic                            o_is_match,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lasc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lasc_pkg::CFG_W-1:0]      i_cfg_data
);
    import lasc_pkg::*;

    localparam logic [SCORE_W-1:0] LEN_MAX = SCORE_W'(PATTERN_MAX);

    logic [CFG_W-1:0]   r_pat_low;
    logic [CFG_W-1:0]   r_pat_high;
    logic [SCORE_W-1:0] r_pat_len;
    logic [SCORE_W-1:0] len_eff;
    logic [2*CFG_W-1:0] pattern;

    t_wave  wave [PATTERN_MAX+1];
    t_score r_best, n_best;
    t_score best_all;
    logic   r_out_valid, n_out_valid;
    t_score r_out_score, n_out_score;
    logic   advance;
    t_wave  tail;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern = {r_pat_high, r_pat_low};
    assign len_eff = (r_pat_len > LEN_MAX) ? LEN_MAX : r_pat_len;

    // Stall only when a finished score cannot leave
    assign tail    = wave[PATTERN_MAX];
    assign advance = !(tail.valid && tail.last && r_out_valid && !i_ready);
    assign o_ready = advance;

    // Feed the head of the row
    assign wave[0] = '{valid: i_valid, char_v: i_keyword_char, last: i_keyword_last,
                       left: '0, diag: '0, best: '0};

    // Row of cells, one per pattern position
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        lasc_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_advance      (advance),
            .i_active       (SCORE_W'(j) < len_eff),
            .i_pattern_char (pattern[j*CHAR_W +: CHAR_W]),
            .i_wave         (wave[j]),
            .o_wave         (wave[j+1])
        );
    end

    // Fold the per-byte best into the keyword best; emit on the last byte
    always_comb begin
        best_all    = score_max(r_best, tail.best);
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_ready;
        n_out_score = r_out_score;
        if (advance && tail.valid) begin
            if (tail.last) begin
                n_best      = '0;
                n_out_valid = 1'b1;
                n_out_score = best_all;
            end else begin
                n_best = best_all;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_score <= n_out_score;
    end

    assign o_valid      = r_out_valid;
    assign o_best_score = r_out_score;
    assign o_is_match   = (r_out_score != '0);

endmodule

// ===== src/lasc_checker.sv =====
// ----------------------------------------------------------------------------
// lasc_checker: port-level checks for the local alignment scorer
// Watches the top-level ports over time and is attached by a bind.
// ----------------------------------------------------------------------------
module lasc_checker #(
    parameter int PATTERN_MAX = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [4:0]                      o_best_score,
    input logic                            o_is_match
);
    import lasc_pkg::*;

    localparam logic [SCORE_W-1:0] LEN_MAX = SCORE_W'(PATTERN_MAX);

    // Hold a waiting score until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_best_score))
        else $error("score changed or dropped while stalled");

    // Match flag follows the score
    a_match_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_match == (o_best_score != '0)))
        else $error("match flag disagrees with score");

    // Score never exceeds the pattern capacity
    a_score_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_best_score <= LEN_MAX))
        else $error("score above pattern capacity");

    // Reset leaves no score pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("score pending after reset");

    // Keyword input is refused only while a score waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled with no waiting score");

endmodule

bind local_alignment_score lasc_checker #(.PATTERN_MAX(PATTERN_MAX)) u_lasc_checker (.*);
